// ===== src/dew_pkg.sv =====
// ----------------------------------------------------------------------------
// dew_pkg
// shared constants and types of the directory entry walker
// ----------------------------------------------------------------------------
package dew_pkg;

  localparam int unsigned NAME_MAX_BYTES = 255;
  localparam int unsigned HDR_BYTES      = 9;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_ADDR_W     = 3;

  localparam logic [15:0] BUF_BYTES_RESET = 16'd8192;

  // register index, taken from paddr bit 2
  localparam logic REG_BUFFER_BYTES = 1'b0;

  typedef enum logic {
    KIND_NAME = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  // one queue word: an optional name byte followed by an optional end mark
  typedef struct packed {
    logic        name_vld;
    logic        end_vld;
    logic [31:0] inode;
    logic [15:0] rec_len;
    logic [7:0]  nlen_cut;
    logic [7:0]  ftype;
    logic [7:0]  name_char;
    logic        name_last;
  } qent_t;

endpackage

// ===== src/directory_entry_walker.sv =====
// ----------------------------------------------------------------------------
// directory_entry_walker
// walks ext2-style directory records and emits name bytes and an end word
// ----------------------------------------------------------------------------
// input words carry one buffer byte each; in_first_byte marks offset zero and
// restarts the walk. each record has a 9-byte little-endian header (inode,
// record length, name length, type) followed by the name. every name byte
// of a usable record comes out as one word with the header fields, cut to
// 255 bytes; one end word (result_kind 1, other fields zero) marks the stop.
// a byte can give a name word and an end word, in that order.
// one input word is taken per cycle while in_stall is low; each result word
// passes through the queue and then the output register. the result side
// delivers one word per cycle while out_stall is low.
// a four-word queue sits between classification and output; in_stall rises
// only while that queue is full, so output stalls reach the input once the
// output register and all four queue words are held.
// reset empties the queue, sets buffer_bytes to 8192 and leaves the walker
// idle until the next first-byte mark. buffer_bytes is at byte address 0.
// ----------------------------------------------------------------------------
module directory_entry_walker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_first_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_result_kind,
  output logic [31:0]                    out_entry_inode,
  output logic [15:0]                    out_entry_record_length,
  output logic [7:0]                     out_entry_name_length,
  output logic [7:0]                     out_entry_type,
  output logic [7:0]                     out_name_char,
  output logic                           out_name_last,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dew_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import dew_pkg::*;

  logic [15:0] buf_bytes_r, buf_bytes_nxt;
  logic        cfg_wr;
  logic        q_push, q_pop, q_empty, q_full;
  qent_t       q_in, q_head;

  always_comb begin
    cfg_pready    = 1'b1;
    cfg_wr        = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
    buf_bytes_nxt = buf_bytes_r;
    if (cfg_wr && cfg_paddr[2] == REG_BUFFER_BYTES) begin
      buf_bytes_nxt = cfg_pwdata[15:0];
    end
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_BUFFER_BYTES) begin
      cfg_prdata = {16'b0, buf_bytes_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_bytes_r <= BUF_BYTES_RESET;
    end else begin
      buf_bytes_r <= buf_bytes_nxt;
    end
  end

  dew_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .buffer_bytes  (buf_bytes_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_ent         (q_in)
  );

  dew_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  dew_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .head                    (q_head),
    .q_empty                 (q_empty),
    .q_pop                   (q_pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_result_kind         (out_result_kind),
    .out_entry_inode         (out_entry_inode),
    .out_entry_record_length (out_entry_record_length),
    .out_entry_name_length   (out_entry_name_length),
    .out_entry_type          (out_entry_type),
    .out_name_char           (out_name_char),
    .out_name_last           (out_name_last)
  );

endmodule

// ===== src/dew_front.sv =====
// ----------------------------------------------------------------------------
// dew_front
// accepts buffer bytes, tracks the record header and classifies each byte
// ----------------------------------------------------------------------------
module dew_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_data_byte,
  input  logic           in_first_byte,
  input  logic [15:0]    buffer_bytes,
  input  logic           q_full,
  output logic           q_push,
  output dew_pkg::qent_t q_ent
);
  import dew_pkg::*;

  localparam logic [15:0] OFS_RLEN = 16'd4;
  localparam logic [15:0] OFS_NLEN = 16'd6;
  localparam logic [15:0] OFS_TYPE = 16'd8;
  localparam logic [15:0] HDR_W16  = 16'(HDR_BYTES);
  localparam logic [15:0] NMAX16   = 16'(NAME_MAX_BYTES);

  logic [15:0] k_r, k_nxt;
  logic [15:0] rs_r, rs_nxt;
  logic [31:0] inode_r, inode_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic [15:0] nlen_r, nlen_nxt;
  logic [7:0]  typ_r, typ_nxt;
  logic        stopped_r, stopped_nxt;
  logic        evalid_r, evalid_nxt;

  logic        acc, active, short_buf;
  logic [15:0] k_c, rs_c, rlen_c, nlen_c, rlen_h, nlen_h;
  logic [31:0] inode_c, inode_h;
  logic [7:0]  typ_c, typ_h;
  logic        evalid_c;
  logic [16:0] rs_plus_len;
  logic [17:0] next_hdr_end;
  logic        bad_hdr, ent_ok, name_hit, rec_end, end_after;
  logic [7:0]  cut_len;
  logic [15:0] idx;

  always_comb begin
    acc       = in_valid && !q_full;
    in_stall  = q_full;
    short_buf = in_first_byte && (buffer_bytes < HDR_W16);
    active    = (in_first_byte || !stopped_r) && !short_buf;

    k_c      = in_first_byte ? '0 : k_r;
    rs_c     = in_first_byte ? '0 : rs_r;
    inode_c  = in_first_byte ? '0 : inode_r;
    rlen_c   = in_first_byte ? '0 : rlen_r;
    nlen_c   = in_first_byte ? '0 : nlen_r;
    typ_c    = in_first_byte ? '0 : typ_r;
    evalid_c = in_first_byte ? 1'b0 : evalid_r;

    // header capture, little endian, or-accumulated
    inode_h = inode_c;
    rlen_h  = rlen_c;
    nlen_h  = nlen_c;
    typ_h   = typ_c;
    if (k_c < OFS_RLEN) begin
      inode_h = inode_c | ({24'b0, in_data_byte} << {k_c[1:0], 3'b000});
    end else if (k_c < OFS_NLEN) begin
      rlen_h = rlen_c | ({8'b0, in_data_byte} << {k_c[0], 3'b000});
    end else if (k_c < OFS_TYPE) begin
      nlen_h = nlen_c | ({8'b0, in_data_byte} << {k_c[0], 3'b000});
    end else if (k_c == OFS_TYPE) begin
      typ_h = in_data_byte;
    end

    rs_plus_len = {1'b0, rs_c} + {1'b0, rlen_h};
    bad_hdr     = (k_c == OFS_TYPE) &&
                  ((rlen_h == '0) || (rs_plus_len > {1'b0, buffer_bytes}));
    ent_ok      = (inode_h != '0) && (nlen_h != '0) &&
                  (({1'b0, nlen_h} + {1'b0, HDR_W16}) <= {1'b0, rlen_h});

    cut_len  = (nlen_h > NMAX16) ? NMAX16[7:0] : nlen_h[7:0];
    idx      = k_c - HDR_W16;
    name_hit = (k_c > OFS_TYPE) && evalid_c && (idx < {8'b0, cut_len});

    rec_end      = !bad_hdr && (k_c >= OFS_TYPE) &&
                   (({1'b0, k_c} + 17'd1) == {1'b0, rlen_h});
    next_hdr_end = {1'b0, rs_plus_len} + {2'b0, HDR_W16};
    end_after    = rec_end && (next_hdr_end > {2'b0, buffer_bytes});

    q_ent.name_vld  = active && name_hit;
    q_ent.end_vld   = short_buf || (active && (bad_hdr || end_after));
    q_ent.inode     = inode_h;
    q_ent.rec_len   = rlen_h;
    q_ent.nlen_cut  = cut_len;
    q_ent.ftype     = typ_h;
    q_ent.name_char = in_data_byte;
    q_ent.name_last = ((idx + 16'd1) == {8'b0, cut_len});
    q_push          = acc && (q_ent.name_vld || q_ent.end_vld);

    k_nxt       = k_r;
    rs_nxt      = rs_r;
    inode_nxt   = inode_r;
    rlen_nxt    = rlen_r;
    nlen_nxt    = nlen_r;
    typ_nxt     = typ_r;
    stopped_nxt = stopped_r;
    evalid_nxt  = evalid_r;
    if (acc) begin
      if (short_buf) begin
        k_nxt       = '0;
        rs_nxt      = '0;
        inode_nxt   = '0;
        rlen_nxt    = '0;
        nlen_nxt    = '0;
        typ_nxt     = '0;
        evalid_nxt  = 1'b0;
        stopped_nxt = 1'b1;
      end else if (active) begin
        k_nxt       = k_c + 16'd1;
        rs_nxt      = rs_c;
        inode_nxt   = inode_h;
        rlen_nxt    = rlen_h;
        nlen_nxt    = nlen_h;
        typ_nxt     = typ_h;
        evalid_nxt  = (k_c == OFS_TYPE) ? ent_ok : evalid_c;
        stopped_nxt = bad_hdr;
        if (rec_end) begin
          k_nxt       = '0;
          rs_nxt      = rs_plus_len[15:0];
          inode_nxt   = '0;
          rlen_nxt    = '0;
          nlen_nxt    = '0;
          typ_nxt     = '0;
          evalid_nxt  = 1'b0;
          stopped_nxt = end_after;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      rs_r      <= '0;
      inode_r   <= '0;
      rlen_r    <= '0;
      nlen_r    <= '0;
      typ_r     <= '0;
      stopped_r <= 1'b1;
      evalid_r  <= 1'b0;
    end else begin
      k_r       <= k_nxt;
      rs_r      <= rs_nxt;
      inode_r   <= inode_nxt;
      rlen_r    <= rlen_nxt;
      nlen_r    <= nlen_nxt;
      typ_r     <= typ_nxt;
      stopped_r <= stopped_nxt;
      evalid_r  <= evalid_nxt;
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_quiet_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (stopped_r && !in_first_byte) |-> !q_push)
    else $error("result produced after walk stopped");

endmodule

// ===== src/dew_queue.sv =====
// ----------------------------------------------------------------------------
// dew_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module dew_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dew_pkg::qent_t push_ent,
  input  logic           pop,
  output dew_pkg::qent_t head,
  output logic           empty,
  output logic           full
);
  import dew_pkg::*;

  qent_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    empty    = (cnt_r == '0);
    full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
    head     = mem_r[rptr_r];
    wptr_nxt = push ? QPTR_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = pop ? QPTR_W'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

// ===== src/dew_back.sv =====
// ----------------------------------------------------------------------------
// dew_back
// drains queue words into the registered result channel
// ----------------------------------------------------------------------------
module dew_back (
  input  logic           clk,
  input  logic           rst_n,
  input  dew_pkg::qent_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_result_kind,
  output logic [31:0]    out_entry_inode,
  output logic [15:0]    out_entry_record_length,
  output logic [7:0]     out_entry_name_length,
  output logic [7:0]     out_entry_type,
  output logic [7:0]     out_name_char,
  output logic           out_name_last
);
  import dew_pkg::*;

  logic        vld_r, vld_nxt;
  logic        phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [31:0] inode_r, inode_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic [7:0]  nlen_r, nlen_nxt;
  logic [7:0]  typ_r, typ_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic        last_r, last_nxt;
  logic        can_load;

  always_comb begin
    can_load  = !vld_r || !out_stall;
    q_pop     = 1'b0;
    vld_nxt   = vld_r && out_stall;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    inode_nxt = inode_r;
    rlen_nxt  = rlen_r;
    nlen_nxt  = nlen_r;
    typ_nxt   = typ_r;
    ch_nxt    = ch_r;
    last_nxt  = last_r;
    if (can_load && !q_empty) begin
      vld_nxt = 1'b1;
      if (!phase_r && head.name_vld) begin
        kind_nxt  = KIND_NAME;
        inode_nxt = head.inode;
        rlen_nxt  = head.rec_len;
        nlen_nxt  = head.nlen_cut;
        typ_nxt   = head.ftype;
        ch_nxt    = head.name_char;
        last_nxt  = head.name_last;
        if (head.end_vld) begin
          phase_nxt = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        // end mark carries zero fields
        kind_nxt  = KIND_END;
        inode_nxt = '0;
        rlen_nxt  = '0;
        nlen_nxt  = '0;
        typ_nxt   = '0;
        ch_nxt    = '0;
        last_nxt  = 1'b0;
        phase_nxt = 1'b0;
        q_pop     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
      kind_r  <= KIND_NAME;
    end else begin
      vld_r   <= vld_nxt;
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inode_r <= inode_nxt;
    rlen_r  <= rlen_nxt;
    nlen_r  <= nlen_nxt;
    typ_r   <= typ_nxt;
    ch_r    <= ch_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid               = vld_r;
  assign out_result_kind         = kind_r;
  assign out_entry_inode         = inode_r;
  assign out_entry_record_length = rlen_r;
  assign out_entry_name_length   = nlen_r;
  assign out_entry_type          = typ_r;
  assign out_name_char           = ch_r;
  assign out_name_last           = last_r;

  a_end_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && kind_r == KIND_END) |->
      (inode_r == '0 && rlen_r == '0 && nlen_r == '0 && typ_r == '0 &&
       ch_r == '0 && !last_r))
    else $error("end word with nonzero fields");

  a_phase_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_empty)
    else $error("pending end mark without queue word");

endmodule

// ===== sim/dew_walk_checker.sv =====
// ----------------------------------------------------------------------------
// dew_walk_checker
// predicts and checks the result words of the directory entry walker
// ----------------------------------------------------------------------------
// watches the byte channel, the result channel and register writes. every
// byte taken is run through a local copy of the walker state; the words it
// should give are queued and matched in order against the words taken from
// the result channel. mismatches and unexpected words raise the fail count.
// ----------------------------------------------------------------------------
module dew_walk_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_first_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_result_kind,
  input  logic [31:0]                    out_entry_inode,
  input  logic [15:0]                    out_entry_record_length,
  input  logic [7:0]                     out_entry_name_length,
  input  logic [7:0]                     out_entry_type,
  input  logic [7:0]                     out_name_char,
  input  logic                           out_name_last,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic                           cfg_pready,
  input  logic [dew_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output int                             fail_count,
  output int                             words_open
);
  timeunit 1ns;
  timeprecision 1ps;
  import dew_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [31:0] inode;
    logic [15:0] rec_len;
    logic [7:0]  nlen_cut;
    logic [7:0]  ftype;
    logic [7:0]  name_char;
    logic        name_last;
  } dir_word_t;

  dir_word_t   expected_words[$];
  int          errors;

  logic [15:0] buf_bytes;
  logic [15:0] byte_ofs;
  logic [15:0] rec_start;
  logic [31:0] hdr_inode;
  logic [15:0] hdr_rec_len;
  logic [15:0] hdr_name_len;
  logic [7:0]  hdr_type;
  logic        walk_idle;
  logic        entry_ok;

  initial begin
    errors     = 0;
    fail_count = 0;
    words_open = 0;
  end

  task automatic clear_header();
    hdr_inode    = '0;
    hdr_rec_len  = '0;
    hdr_name_len = '0;
    hdr_type     = '0;
    entry_ok     = 1'b0;
  endtask

  task automatic queue_end_word();
    dir_word_t w;
    w = '{kind: KIND_END, inode: '0, rec_len: '0, nlen_cut: '0, ftype: '0,
          name_char: '0, name_last: 1'b0};
    expected_words.push_back(w);
  endtask

  task automatic walk_byte(input logic [7:0] b, input logic first);
    logic [15:0] k;
    int unsigned idx;
    int unsigned len;
    int unsigned next_start;
    dir_word_t   w;
    if (first) begin
      byte_ofs  = '0;
      rec_start = '0;
      clear_header();
      walk_idle = 1'b0;
      if (HDR_BYTES > int'(buf_bytes)) begin
        walk_idle = 1'b1;
        queue_end_word();
        return;
      end
    end else if (walk_idle) begin
      return;
    end
    k = byte_ofs - rec_start;
    if (k < 4)
      hdr_inode = hdr_inode | (32'(b) << (8 * k));
    else if (k < 6)
      hdr_rec_len = hdr_rec_len | (16'(b) << (8 * (k - 4)));
    else if (k < 8)
      hdr_name_len = hdr_name_len | (16'(b) << (8 * (k - 6)));
    else if (k == 8)
      hdr_type = b;

    if (k == 8) begin
      if (hdr_rec_len == 0 ||
          32'(rec_start) + 32'(hdr_rec_len) > 32'(buf_bytes)) begin
        walk_idle = 1'b1;
        queue_end_word();
        return;
      end
      entry_ok = hdr_inode != 0 && hdr_name_len != 0 &&
                 HDR_BYTES + 32'(hdr_name_len) <= 32'(hdr_rec_len);
    end else if (k > 8 && entry_ok) begin
      idx = 32'(k) - HDR_BYTES;
      len = (32'(hdr_name_len) > NAME_MAX_BYTES) ? NAME_MAX_BYTES : 32'(hdr_name_len);
      if (idx < len) begin
        w = '{kind: KIND_NAME, inode: hdr_inode, rec_len: hdr_rec_len,
              nlen_cut: 8'(len), ftype: hdr_type, name_char: b,
              name_last: (idx + 1 == len)};
        expected_words.push_back(w);
      end
    end

    if (k >= 8 && 32'(k) + 1 == 32'(hdr_rec_len)) begin
      next_start = 32'(rec_start) + 32'(hdr_rec_len);
      clear_header();
      if (next_start + HDR_BYTES > 32'(buf_bytes)) begin
        walk_idle = 1'b1;
        queue_end_word();
      end
      rec_start = next_start[15:0];
    end
    byte_ofs = byte_ofs + 16'd1;
  endtask

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_result_word();
    dir_word_t w;
    if (expected_words.size() == 0) begin
      $error("result word with nothing expected: kind %0d", out_result_kind);
      errors++;
      return;
    end
    w = expected_words.pop_front();
    errors += field_differs("result_kind", 32'(w.kind), 32'(out_result_kind));
    errors += field_differs("entry_inode", w.inode, out_entry_inode);
    errors += field_differs("entry_record_length", 32'(w.rec_len),
                            32'(out_entry_record_length));
    errors += field_differs("entry_name_length", 32'(w.nlen_cut),
                            32'(out_entry_name_length));
    errors += field_differs("entry_type", 32'(w.ftype), 32'(out_entry_type));
    errors += field_differs("name_char", 32'(w.name_char), 32'(out_name_char));
    errors += field_differs("name_last", 32'(w.name_last), 32'(out_name_last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      buf_bytes = BUF_BYTES_RESET;
      byte_ofs  = '0;
      rec_start = '0;
      clear_header();
      walk_idle = 1'b1;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall)
        check_result_word();
      if (in_valid && !in_stall)
        walk_byte(in_data_byte, in_first_byte);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_BUFFER_BYTES)
        buf_bytes = cfg_pwdata[15:0];
    end
    fail_count <= errors;
    words_open <= expected_words.size();
  end

endmodule

// ===== sim/tb_directory_entry_walker.sv =====
// ----------------------------------------------------------------------------
// tb_directory_entry_walker
// stimulus and verdict for the directory entry walker
// ----------------------------------------------------------------------------
// a pair of hand-made buffers first, then random directory walks built from
// mostly well-formed records with random content, broken records and noise,
// over a range of buffer sizes. both channels idle at random; once the
// result side holds off long enough to back up the input. the checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_directory_entry_walker;
  timeunit 1ns;
  timeprecision 1ps;
  import dew_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1200000;
  localparam int unsigned TARGET_ITEMS = 1450;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [CFG_ADDR_W-1:0] BUFFER_BYTES_ADDR = {REG_BUFFER_BYTES, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_data_byte;
  logic                  in_first_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_result_kind;
  logic [31:0]           out_entry_inode;
  logic [15:0]           out_entry_record_length;
  logic [7:0]            out_entry_name_length;
  logic [7:0]            out_entry_type;
  logic [7:0]            out_name_char;
  logic                  out_name_last;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int                    fail_count;
  int                    words_open;
  int unsigned           cycle_count;
  int                    burst_left;
  bit                    hold_req;
  bit                    hold_done;
  logic [7:0]            walk_q[$];

  directory_entry_walker dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_data_byte            (in_data_byte),
    .in_first_byte           (in_first_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_result_kind         (out_result_kind),
    .out_entry_inode         (out_entry_inode),
    .out_entry_record_length (out_entry_record_length),
    .out_entry_name_length   (out_entry_name_length),
    .out_entry_type          (out_entry_type),
    .out_name_char           (out_name_char),
    .out_name_last           (out_name_last),
    .cfg_psel                (cfg_psel),
    .cfg_penable             (cfg_penable),
    .cfg_pwrite              (cfg_pwrite),
    .cfg_paddr               (cfg_paddr),
    .cfg_pwdata              (cfg_pwdata),
    .cfg_prdata              (cfg_prdata),
    .cfg_pready              (cfg_pready)
  );

  dew_walk_checker chk (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_data_byte            (in_data_byte),
    .in_first_byte           (in_first_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_result_kind         (out_result_kind),
    .out_entry_inode         (out_entry_inode),
    .out_entry_record_length (out_entry_record_length),
    .out_entry_name_length   (out_entry_name_length),
    .out_entry_type          (out_entry_type),
    .out_name_char           (out_name_char),
    .out_name_last           (out_name_last),
    .cfg_psel                (cfg_psel),
    .cfg_penable             (cfg_penable),
    .cfg_pwrite              (cfg_pwrite),
    .cfg_pready              (cfg_pready),
    .cfg_paddr               (cfg_paddr),
    .cfg_pwdata              (cfg_pwdata),
    .fail_count              (fail_count),
    .words_open              (words_open)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, quiet stretches and one long hold
  initial begin
    int s;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < 12) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 100)) @(posedge clk);
      end else begin
        s = idle_cycles();
        if (s > 0) begin
          out_stall <= 1'b1;
          repeat (s) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_first_byte <= first;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = idle_cycles();
      if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(30, 120);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_walk();
    foreach (walk_q[i]) send_byte(walk_q[i], i == 0);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (words_open != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= BUFFER_BYTES_ADDR;
    cfg_pwdata  <= {16'($urandom_range(0, 65535)), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [15:0] pick_buffer_bytes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom_range(0, 8));
    if (r < 22) return 16'hFFFF;
    if (r < 32) return 16'($urandom_range(9, 12));
    if (r < 42) return 16'd512;
    if (r < 47) return BUF_BYTES_RESET;
    return 16'($urandom_range(20, 400));
  endfunction

  task automatic put_random_bytes(input int n);
    repeat (n) walk_q.push_back(8'($urandom));
  endtask

  // one walk: now and then pure noise, else records up to the buffer end or a
  // byte cap, then up to four bytes that the walker should ignore once stopped
  task automatic build_walk(input int unsigned buf_len);
    int unsigned pos;
    int unsigned cap;
    int unsigned room;
    int unsigned nl;
    int unsigned rl;
    int          r;
    logic [31:0] ino;
    bit          done;
    walk_q.delete();
    if ($urandom_range(0, 99) < 12) begin
      put_random_bytes($urandom_range(1, 30));
      return;
    end
    pos  = 0;
    done = 1'b0;
    cap  = ($urandom_range(0, 99) < 6) ? 400 : $urandom_range(20, 90);
    while (!done && pos + HDR_BYTES <= buf_len && pos < cap) begin
      room = buf_len - pos;
      if ($urandom_range(0, 9) == 0) ino = '0;
      else if ($urandom_range(0, 1) == 1) ino = $urandom;
      else ino = $urandom_range(1, 1000);
      r  = $urandom_range(0, 99);
      nl = $urandom_range(1, 12);
      if (r < 6) nl = 0;
      else if (r < 50 && cap > 300 && pos == 0 && room >= 300) nl = $urandom_range(250, 290);
      rl = HDR_BYTES + nl + $urandom_range(0, 3);
      r  = $urandom_range(0, 99);
      if (r < 4) begin
        rl   = 0;
        done = 1'b1;
      end else if (r < 8) begin
        rl = room + $urandom_range(1, 40);
        if (rl > 65535) rl = 65535;
        done = 1'b1;
      end else if (r < 14) begin
        nl = rl - HDR_BYTES + $urandom_range(1, 6);
      end else if (rl <= room && room - rl < HDR_BYTES && $urandom_range(0, 1) == 1) begin
        rl = room;
      end
      if (rl > room) done = 1'b1;
      for (int i = 0; i < 4; i++) walk_q.push_back(ino[8*i +: 8]);
      walk_q.push_back(rl[7:0]);
      walk_q.push_back(rl[15:8]);
      walk_q.push_back(nl[7:0]);
      walk_q.push_back(nl[15:8]);
      walk_q.push_back(8'($urandom));
      if (done) put_random_bytes($urandom_range(0, 4));
      else put_random_bytes(rl - HDR_BYTES);
      pos += rl;
    end
    if (!done && pos + HDR_BYTES > buf_len) put_random_bytes($urandom_range(0, 3));
    if (walk_q.size() == 0) put_random_bytes($urandom_range(1, 3));
  endtask

  initial begin
    int unsigned items;
    int          phase;
    logic [15:0] setting;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_byte  <= '0;
    in_first_byte <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    hold_req      = 1'b0;
    burst_left    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two valid records filling the buffer: the last name byte and the end
    // word come from the same byte, then one byte after the stop
    cfg_write(16'd21);
    walk_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
               8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0B, 8'h00, 8'h02, 8'h00, 8'hFF,
               8'h7F, 8'hFF, 8'hA5};
    send_walk();
    wait_quiet();
    // empty buffer ends on the first byte
    cfg_write(16'd0);
    walk_q = '{8'h5A};
    send_walk();
    wait_quiet();

    items = 0;
    phase = 0;
    while (items < TARGET_ITEMS) begin
      setting = (phase == 0) ? 16'hFFFF : pick_buffer_bytes();
      cfg_write(setting);
      if (phase == 0) hold_req = 1'b1;
      repeat ($urandom_range(2, 6)) begin
        if (items < TARGET_ITEMS) begin
          build_walk(setting);
          items += walk_q.size();
          send_walk();
        end
      end
      wait_quiet();
      phase++;
    end

    wait_quiet();
    if (fail_count == 0 && words_open == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
